/* rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/hsa_pkg.sv */
package hsa_pkg;

    localparam int HANDLE_BITS       = 32;
    localparam int NODE_BITS         = 8;
    localparam int CONTEXT_PORT_BITS = 16;
    localparam int CMD_BITS          = 2;
    localparam int STATUS_BITS       = 2;
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic [CMD_BITS-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RETIRE   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_GRAB     = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [0:0] REG_NODE_ID = 1'b0;

    typedef struct packed {
        logic [STATUS_BITS-1:0]       status;
        logic [HANDLE_BITS-1:0]       handle;
        logic [CONTEXT_PORT_BITS-1:0] context_id;
    } t_result;

endpackage

/* rtl/hsa_ram.sv */
module hsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/handle_slot_allocator.sv */
// Channel   Direction  Handshake              Payload
// input     in         i_in_valid/o_in_stall  i_command, i_context_id, i_handle_in
// output    out        o_out_valid/i_out_stall o_status, o_handle_out, o_context_out
// config    in         APB write/read         node_id at byte address 0
//
// Retire and grab read one slot table entry; a retire that hits writes it back
// invalid. Register checks slots from the next-fit index until one is free, up to
// min(SLOTS, 2**INDEX_BITS) slots, since the single table read port checks one
// candidate slot per cycle.
// After reset a clearing pass empties all SLOTS table entries; input stalls.
// A finished result waits in the output register while the next transaction
// is accepted; a full output register holds the search or lookup in place.
`include "assert_macros.svh"

module handle_slot_allocator #(
    parameter int SLOTS        = 1024,
    parameter int INDEX_BITS   = 24,
    parameter int CONTEXT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [hsa_pkg::CMD_BITS-1:0]             i_command,
    input  logic [hsa_pkg::CONTEXT_PORT_BITS-1:0]    i_context_id,
    input  logic [hsa_pkg::HANDLE_BITS-1:0]          i_handle_in,

    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [hsa_pkg::STATUS_BITS-1:0]          o_status,
    output logic [hsa_pkg::HANDLE_BITS-1:0]          o_handle_out,
    output logic [hsa_pkg::CONTEXT_PORT_BITS-1:0]    o_context_out,

    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [hsa_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  logic [hsa_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [hsa_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready
);

    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int INDEX_SPAN = 1 << INDEX_BITS;
    localparam int SEARCH_LEN = (SLOTS < INDEX_SPAN) ? SLOTS : INDEX_SPAN;
    localparam int CNT_BITS   = $clog2(SEARCH_LEN);
    localparam int ENTRY_BITS = 1 + hsa_pkg::HANDLE_BITS + CONTEXT_BITS;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);
    localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(SEARCH_LEN - 1);

    typedef struct packed {
        logic                            valid;
        logic [hsa_pkg::HANDLE_BITS-1:0] handle;
        logic [CONTEXT_BITS-1:0]         ctx;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_LOOKUP
    } t_state;

    t_state                          r_state, n_state;
    logic [SLOT_BITS-1:0]            r_clr_addr, n_clr_addr;
    logic [INDEX_BITS-1:0]           r_next_index, n_next_index;
    logic [INDEX_BITS-1:0]           r_idx, n_idx;
    logic [CNT_BITS-1:0]             r_cnt, n_cnt;
    logic [hsa_pkg::CMD_BITS-1:0]    r_cmd, n_cmd;
    logic [CONTEXT_BITS-1:0]         r_ctx, n_ctx;
    logic [hsa_pkg::HANDLE_BITS-1:0] r_handle, n_handle;
    logic [hsa_pkg::NODE_BITS-1:0]   r_node_id, n_node_id;
    logic                            r_out_valid, n_out_valid;
    hsa_pkg::t_result                r_result, n_result;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_cfg_wr;
    logic                            w_hit;
    logic [hsa_pkg::HANDLE_BITS-1:0] w_cand_handle;
    logic                            w_we;
    logic [SLOT_BITS-1:0]            w_waddr;
    t_entry                          w_wdata;
    logic [SLOT_BITS-1:0]            w_raddr;
    logic [ENTRY_BITS-1:0]           w_rdata;
    t_entry                          w_rd;

    hsa_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd          = t_entry'(w_rdata);
    assign w_in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_cand_handle = hsa_pkg::HANDLE_BITS'({r_node_id, r_idx});
    assign w_hit         = w_rd.valid && (w_rd.handle == r_handle) &&
                           ((r_cmd == hsa_pkg::CMD_RETIRE) || (r_cmd == hsa_pkg::CMD_GRAB));
    assign w_cfg_wr      = psel && penable && pwrite &&
                           (paddr[hsa_pkg::APB_ADDR_BITS-1:2] == hsa_pkg::REG_NODE_ID);

    assign pready = 1'b1;
    assign prdata = (paddr[hsa_pkg::APB_ADDR_BITS-1:2] == hsa_pkg::REG_NODE_ID) ?
                    hsa_pkg::APB_DATA_BITS'(r_node_id) : '0;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_next_index = r_next_index;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_ctx        = r_ctx;
        n_handle     = r_handle;
        n_node_id    = r_node_id;
        n_out_valid  = r_out_valid && i_out_stall;
        n_result     = r_result;
        w_we         = 1'b0;
        w_waddr      = r_clr_addr;
        w_wdata      = '0;
        w_raddr      = SLOT_BITS'(r_idx);

        if (w_cfg_wr) begin
            n_node_id = pwdata[hsa_pkg::NODE_BITS-1:0];
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + SLOT_BITS'(1);
                if (r_clr_addr == SLOT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cmd    = i_command;
                    n_ctx    = CONTEXT_BITS'(i_context_id);
                    n_handle = i_handle_in;
                    if (i_command == hsa_pkg::CMD_REGISTER) begin
                        n_state = ST_SEARCH;
                        n_idx   = r_next_index;
                        n_cnt   = '0;
                        w_raddr = SLOT_BITS'(r_next_index);
                    end else begin
                        n_state = ST_LOOKUP;
                        w_raddr = SLOT_BITS'(i_handle_in);
                    end
                end
            end
            ST_SEARCH: begin
                if (!w_rd.valid) begin
                    if (w_out_free) begin
                        w_we         = 1'b1;
                        w_waddr      = SLOT_BITS'(r_idx);
                        w_wdata      = '{valid: 1'b1, handle: w_cand_handle, ctx: r_ctx};
                        n_next_index = r_idx + INDEX_BITS'(1);
                        n_out_valid  = 1'b1;
                        n_result     = '{status: hsa_pkg::STATUS_OK,
                                         handle: w_cand_handle, context_id: '0};
                        n_state      = ST_IDLE;
                    end
                end else if (r_cnt == CNT_LAST) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_result    = '{status: hsa_pkg::STATUS_FULL,
                                        handle: '0, context_id: '0};
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + INDEX_BITS'(1);
                    n_cnt   = r_cnt + CNT_BITS'(1);
                    w_raddr = SLOT_BITS'(r_idx + INDEX_BITS'(1));
                end
            end
            ST_LOOKUP: begin
                w_raddr = SLOT_BITS'(r_handle);
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (w_hit) begin
                        n_result = '{status: hsa_pkg::STATUS_OK, handle: '0,
                                     context_id: hsa_pkg::CONTEXT_PORT_BITS'(w_rd.ctx)};
                        if (r_cmd == hsa_pkg::CMD_RETIRE) begin
                            w_we    = 1'b1;
                            w_waddr = SLOT_BITS'(r_handle);
                            w_wdata = '{valid: 1'b0, handle: w_rd.handle, ctx: w_rd.ctx};
                        end
                    end else begin
                        n_result = '{status: hsa_pkg::STATUS_NOT_FOUND,
                                     handle: '0, context_id: '0};
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_next_index <= INDEX_BITS'(1);
            r_node_id    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_next_index <= n_next_index;
            r_node_id    <= n_node_id;
            r_out_valid  <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_ctx    <= n_ctx;
        r_handle <= n_handle;
        r_result <= n_result;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_handle_out  = r_result.handle;
    assign o_context_out = r_result.context_id;

    `ASSERT_CLK(a_clear_no_result, i_clk, i_rst_n, (r_state == ST_CLEAR) |-> !r_out_valid, "Result present during table clearing.")
    `ASSERT_CLK(a_idle_no_write, i_clk, i_rst_n, w_we |-> (r_state != ST_IDLE), "Table written while idle.")
    `ASSERT_CLK(a_index_moves_on_search, i_clk, i_rst_n, (r_next_index != $past(r_next_index)) |-> ($past(r_state) == ST_SEARCH), "Next index changed outside a search.")
    `ASSERT_CLK(a_lookup_write_is_retire, i_clk, i_rst_n, ((r_state == ST_LOOKUP) && w_we) |-> (!w_wdata.valid && (r_cmd == hsa_pkg::CMD_RETIRE)), "Lookup wrote the table without a retire.")

endmodule

/* verif/handle_slot_allocator_tb.sv */
`timescale 1ns / 100ps

module handle_slot_allocator_tb;
    import hsa_pkg::*;

    localparam int SLOTS          = 1024;
    localparam int INDEX_BITS     = 24;
    localparam int CONTEXT_BITS   = 16;
    localparam int SLOT_BITS      = $clog2(SLOTS);
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [CMD_BITS-1:0]      CMD_UNKNOWN  = 2'd3;
    localparam logic [APB_ADDR_BITS-1:0] NODE_ID_ADDR = {REG_NODE_ID, 2'b00};

    typedef enum int {STALL_OFF, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [CMD_BITS-1:0]          i_command = '0;
    logic [CONTEXT_PORT_BITS-1:0] i_context_id = '0;
    logic [HANDLE_BITS-1:0]       i_handle_in = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [STATUS_BITS-1:0]       o_status;
    logic [HANDLE_BITS-1:0]       o_handle_out;
    logic [CONTEXT_PORT_BITS-1:0] o_context_out;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr = '0;
    logic [APB_DATA_BITS-1:0]     pwdata = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    // Shadow copy of the slot table and allocation state.
    logic                         slot_used   [SLOTS];
    logic [HANDLE_BITS-1:0]       slot_handle [SLOTS];
    logic [CONTEXT_PORT_BITS-1:0] slot_owner  [SLOTS];
    logic [INDEX_BITS-1:0]        next_fit_index;
    logic [NODE_BITS-1:0]         node_number;
    int                           slots_in_use;

    t_result     pending_results[$];
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          n_register = 0;
    int          n_full = 0;
    int          n_retire = 0;
    int          n_grab = 0;
    int          n_unknown = 0;
    int          n_missed = 0;
    int          n_node_writes = 0;

    t_stall_mode stall_mode = STALL_OFF;
    bit          sender_idles = 1'b0;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_phase = 0;
    int          quiet_cycles = 0;

    handle_slot_allocator #(
        .SLOTS       (SLOTS),
        .INDEX_BITS  (INDEX_BITS),
        .CONTEXT_BITS(CONTEXT_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_context_id (i_context_id),
        .i_handle_in  (i_handle_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_context_out(o_context_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_slot_table();
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
            slot_handle[s] = '0;
            slot_owner[s] = '0;
        end
        next_fit_index = INDEX_BITS'(1);
        node_number = '0;
        slots_in_use = 0;
    endfunction

    function automatic t_result allocate_or_lookup(input logic [CMD_BITS-1:0] cmd,
            input logic [CONTEXT_PORT_BITS-1:0] ctx, input logic [HANDLE_BITS-1:0] hnd);
        t_result               res;
        logic [INDEX_BITS-1:0] idx;
        logic [SLOT_BITS-1:0]  slot;
        res.status = STATUS_NOT_FOUND;
        res.handle = '0;
        res.context_id = '0;
        slot = hnd[SLOT_BITS-1:0];
        case (cmd)
            CMD_REGISTER: begin
                n_register++;
                res.status = STATUS_FULL;
                idx = next_fit_index;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_used[idx[SLOT_BITS-1:0]]) begin
                        slot = idx[SLOT_BITS-1:0];
                        slot_used[slot] = 1'b1;
                        slot_handle[slot] = {node_number, idx};
                        slot_owner[slot] = ctx;
                        slots_in_use++;
                        next_fit_index = idx + 1'b1;
                        res.status = STATUS_OK;
                        res.handle = slot_handle[slot];
                        break;
                    end
                    idx = idx + 1'b1;
                end
                if (res.status == STATUS_FULL) n_full++;
            end
            CMD_RETIRE, CMD_GRAB: begin
                if (cmd == CMD_RETIRE) n_retire++;
                else n_grab++;
                if (slot_used[slot] && slot_handle[slot] == hnd) begin
                    res.status = STATUS_OK;
                    res.context_id = slot_owner[slot];
                    if (cmd == CMD_RETIRE) begin
                        slot_used[slot] = 1'b0;
                        slots_in_use--;
                    end
                end else begin
                    n_missed++;
                end
            end
            default: n_unknown++;
        endcase
        return res;
    endfunction

    function automatic logic [HANDLE_BITS-1:0] pick_live_handle();
        logic [SLOT_BITS-1:0] s;
        if (slots_in_use == 0) return $urandom;
        s = SLOT_BITS'($urandom);
        while (!slot_used[s]) s++;
        return slot_handle[s];
    endfunction

    task automatic send_txn(input logic [CMD_BITS-1:0] cmd,
            input logic [CONTEXT_PORT_BITS-1:0] ctx, input logic [HANDLE_BITS-1:0] hnd,
            output t_result predicted);
        int gap;
        if (sender_idles && burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_context_id <= ctx;
        i_handle_in <= hnd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = allocate_or_lookup(cmd, ctx, hnd);
        pending_results.push_back(predicted);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [APB_DATA_BITS-1:0] wdata,
            output logic [APB_DATA_BITS-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= NODE_ID_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_node_id_readback();
        logic [APB_DATA_BITS-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata[NODE_BITS-1:0] !== node_number) begin
            mismatch_count++;
            $display("%0t: node ID readback expected %h, got %h", $time, node_number,
                     rdata[NODE_BITS-1:0]);
        end
    endtask

    // Upper write data bits are random, since only the low byte is kept.
    task automatic set_node_id(input logic [NODE_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] wdata;
        logic [APB_DATA_BITS-1:0] rdata;
        wdata = $urandom;
        wdata[NODE_BITS-1:0] = value;
        apb_access(1'b1, wdata, rdata);
        node_number = value;
        n_node_writes++;
        @(posedge i_clk);
        check_node_id_readback();
    endtask

    task automatic test_directed();
        t_result                res;
        logic [HANDLE_BITS-1:0] ha;
        logic [HANDLE_BITS-1:0] hb;
        logic [HANDLE_BITS-1:0] hc;
        sender_idles = 1'b0;
        stall_mode = STALL_OFF;
        check_node_id_readback();
        send_txn(CMD_REGISTER, '0, '0, res);
        ha = res.handle;
        send_txn(CMD_REGISTER, '1, '1, res);
        hb = res.handle;
        send_txn(CMD_GRAB, '0, ha, res);
        send_txn(CMD_GRAB, '0, hb, res);
        send_txn(CMD_RETIRE, '1, ha, res);
        send_txn(CMD_RETIRE, '0, ha, res);
        send_txn(CMD_GRAB, '0, ha, res);
        send_txn(CMD_GRAB, '0, '0, res);
        send_txn(CMD_RETIRE, '0, '1, res);
        send_txn(CMD_GRAB, '0, hb ^ 32'hFF00_0000, res);
        send_txn(CMD_GRAB, '0, hb + SLOTS, res);
        send_txn(CMD_UNKNOWN, '1, hb, res);
        send_txn(CMD_GRAB, '1, hb, res);
        drain_results();
        set_node_id(8'hFF);
        stall_mode = STALL_PERIODIC;
        send_txn(CMD_REGISTER, 16'hA5A5, '0, res);
        hc = res.handle;
        send_txn(CMD_GRAB, '0, hc, res);
        send_txn(CMD_GRAB, '0, hb, res);
        send_txn(CMD_GRAB, '0, {8'h00, hc[INDEX_BITS-1:0]}, res);
        send_txn(CMD_RETIRE, '0, hc, res);
        send_txn(CMD_RETIRE, '0, hb, res);
        drain_results();
        set_node_id(8'h00);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        t_result res;
        sender_idles = 1'b0;
        stall_mode = STALL_OFF;
        @(negedge i_clk);
        hold_requests++;
        @(posedge i_clk);
        for (int n = 0; n < 40; n++) begin
            if (n % 3 == 0) begin
                send_txn(CMD_GRAB, CONTEXT_PORT_BITS'($urandom), pick_live_handle(), res);
            end else begin
                send_txn(CMD_REGISTER, CONTEXT_PORT_BITS'($urandom), $urandom, res);
            end
        end
        drain_results();
    endtask

    task automatic test_table_full();
        t_result res;
        sender_idles = 1'b0;
        stall_mode = STALL_PERIODIC;
        while (slots_in_use < SLOTS) begin
            send_txn(CMD_REGISTER, CONTEXT_PORT_BITS'($urandom), $urandom, res);
        end
        repeat (3) send_txn(CMD_REGISTER, CONTEXT_PORT_BITS'($urandom), $urandom, res);
        sender_idles = 1'b1;
        stall_mode = STALL_RANDOM;
        repeat (8) send_txn(CMD_RETIRE, CONTEXT_PORT_BITS'($urandom), pick_live_handle(), res);
        repeat (10) send_txn(CMD_REGISTER, CONTEXT_PORT_BITS'($urandom), $urandom, res);
        drain_results();
    endtask

    task automatic test_random_mix();
        t_result                res;
        logic [CMD_BITS-1:0]    cmd;
        logic [HANDLE_BITS-1:0] hnd;
        int                     pick;
        int                     flip;
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            if (phase == 0) set_node_id(8'hFF);
            else if (phase == 1) set_node_id(8'h00);
            else set_node_id(NODE_BITS'($urandom));
            stall_mode = t_stall_mode'(phase % 3);
            sender_idles = (phase != 4);
            for (int n = 0; n < 30; n++) begin
                pick = $urandom_range(0, 99);
                hnd = $urandom;
                cmd = $urandom_range(0, 1) ? CMD_RETIRE : CMD_GRAB;
                if (pick < 88 || pick >= 94) hnd = pick_live_handle();
                if (pick >= 94 && pick < 97) begin
                    flip = $urandom_range(SLOT_BITS, HANDLE_BITS - 1);
                    hnd[flip] = ~hnd[flip];
                end
                if (pick >= 97) cmd = CMD_UNKNOWN;
                if (pick < ((slots_in_use < 48) ? 45 : 15)) cmd = CMD_REGISTER;
                send_txn(cmd, CONTEXT_PORT_BITS'($urandom), hnd, res);
                if ($urandom_range(0, 59) == 0) drain_results();
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_OFF:    i_out_stall <= 1'b0;
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 99) < 40);
                default:      i_out_stall <= ((stall_phase % 11) < 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result observed;
        t_result wanted;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            observed = {o_status, o_handle_out, o_context_out};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transaction: status %0d handle %h context %h",
                         $time, observed.status, observed.handle, observed.context_id);
            end else begin
                wanted = pending_results.pop_front();
                results_checked++;
                if (observed !== wanted) begin
                    mismatch_count++;
                    $display("%0t: expected %0d/%h/%h, got %0d/%h/%h", $time,
                             wanted.status, wanted.handle, wanted.context_id,
                             observed.status, observed.handle, observed.context_id);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        clear_slot_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_mix();
        test_table_full();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transactions: %0d register (%0d on a full table),",
                 n_register + n_retire + n_grab + n_unknown, n_register, n_full);
        $display("%0d retire, %0d grab, %0d unknown, %0d missed, %0d node ID writes.",
                 n_retire, n_grab, n_unknown, n_missed, n_node_writes);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hsa_pkg.sv
rtl/hsa_ram.sv
rtl/handle_slot_allocator.sv
verif/handle_slot_allocator_tb.sv
